@@ rtl/core/tcc_pkg.sv @@
// Shared constants, codes and controller/datapath types for the text console engine.
// Depends on nothing; every other file of the block refers to it by scoped names.
package tcc_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = ROWS * COLUMNS;
  localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLUMNS);

  // Fixed field widths of the channels
  localparam int REQ_W   = 3;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int RROW_W  = 5;
  localparam int RCOL_W  = 7;
  localparam int CELL_W  = 16;
  localparam int BEAT_W  = 2;

  // Backspace echoes three beats
  localparam int BKSP_BEATS = 3;

  // Character and attribute codes
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NONE      = 8'h00;
  localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h07;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUT        = 3'd0,
    REQ_BACKSPACE  = 3'd1,
    REQ_CLEAR      = 3'd2,
    REQ_NEWLINE_NZ = 3'd3,
    REQ_READ       = 3'd4
  } req_e;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_PUT,
    OP_NEWLINE,
    OP_BKSP,
    OP_HOME,
    OP_FILL,
    OP_COPY_RD,
    OP_COPY_WR,
    OP_READ,
    OP_EMIT
  } dp_op_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_EMIT
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    dp_op_e op;
    logic   blank_rst;  // fill with the reset cell instead of the current attribute
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             is_newline;
    logic             col_zero;
    logic             col_last;
    logic             row_last;
    logic             copy_phase;
    logic             sweep_last;
    logic             beat_last;
    logic             out_free;
  } dp_stat_t;

endpackage

@@ rtl/core/tcc_if.sv @@
// Request and response channel interfaces of the text console engine.
// Depends on tcc_pkg for field widths.
interface tcc_req_if;
  logic                          valid;
  logic                          ready;
  logic [tcc_pkg::REQ_W-1:0]     req_type;
  logic [tcc_pkg::CHAR_W-1:0]    char_code;
  logic [tcc_pkg::RROW_W-1:0]    read_row;
  logic [tcc_pkg::RCOL_W-1:0]    read_col;

  modport source (output valid, req_type, char_code, read_row, read_col, input ready);
  modport sink   (input valid, req_type, char_code, read_row, read_col, output ready);
endinterface

interface tcc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          serial_valid;
  logic [tcc_pkg::CHAR_W-1:0]    serial_byte;
  logic [tcc_pkg::CELL_W-1:0]    cell_value;
  logic [tcc_pkg::RROW_W-1:0]    cursor_row;
  logic [tcc_pkg::RCOL_W-1:0]    cursor_col;
  logic                          last;

  modport source (output valid, serial_valid, serial_byte, cell_value, cursor_row,
                  cursor_col, last, input ready);
  modport sink   (input valid, serial_valid, serial_byte, cell_value, cursor_row,
                  cursor_col, last, output ready);
endinterface

@@ rtl/core/tcc_datapath.sv @@
// Datapath: screen memory, cursor, attribute register, sweep counter and result register.
// Depends on tcc_pkg; driven one operation per cycle by tcc_ctrl.
module tcc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcc_pkg::dp_cmd_t              cmd_i,
  output tcc_pkg::dp_stat_t             stat_o,
  input  logic                          attr_we_i,
  input  logic [tcc_pkg::ATTR_W-1:0]    attr_wdata_i,
  input  logic [tcc_pkg::REQ_W-1:0]     req_type_i,
  input  logic [tcc_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcc_pkg::RROW_W-1:0]    read_row_i,
  input  logic [tcc_pkg::RCOL_W-1:0]    read_col_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          serial_valid_o,
  output logic [tcc_pkg::CHAR_W-1:0]    serial_byte_o,
  output logic [tcc_pkg::CELL_W-1:0]    cell_value_o,
  output logic [tcc_pkg::RROW_W-1:0]    cursor_row_o,
  output logic [tcc_pkg::RCOL_W-1:0]    cursor_col_o,
  output logic                          last_o
);

  localparam logic [tcc_pkg::ADDR_W-1:0] ColsA    = tcc_pkg::ADDR_W'(tcc_pkg::COLUMNS);
  localparam logic [tcc_pkg::ADDR_W-1:0] LastIdx  = tcc_pkg::ADDR_W'(tcc_pkg::CELLS - 1);
  localparam logic [tcc_pkg::ADDR_W-1:0] CopyEnd  = tcc_pkg::ADDR_W'(tcc_pkg::COPY_CELLS);
  localparam logic [tcc_pkg::ROW_W-1:0]  LastRow  = tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1);
  localparam logic [tcc_pkg::COL_W-1:0]  LastCol  = tcc_pkg::COL_W'(tcc_pkg::COLUMNS - 1);
  localparam logic [tcc_pkg::BEAT_W-1:0] LastBeat = tcc_pkg::BEAT_W'(tcc_pkg::BKSP_BEATS - 1);

  // Screen store
  logic [tcc_pkg::CELL_W-1:0] mem [tcc_pkg::CELLS];
  logic [tcc_pkg::CELL_W-1:0] rdata_q;

  // Captured request
  logic [tcc_pkg::REQ_W-1:0]  req_q;
  logic [tcc_pkg::CHAR_W-1:0] char_q;
  logic [tcc_pkg::RROW_W-1:0] rrow_q;
  logic [tcc_pkg::RCOL_W-1:0] rcol_q;

  // Control state
  logic [tcc_pkg::ROW_W-1:0]  row_q, row_d;
  logic [tcc_pkg::COL_W-1:0]  col_q, col_d;
  logic [tcc_pkg::ATTR_W-1:0] attr_q;
  logic [tcc_pkg::ADDR_W-1:0] idx_q, idx_d;
  logic [tcc_pkg::BEAT_W-1:0] beat_q, beat_d;
  logic                       nl_q, nl_d;
  logic                       rd_ok_q, rd_ok_d;

  // Result register
  logic                       out_valid_q, out_valid_d;
  logic                       sv_q;
  logic [tcc_pkg::CHAR_W-1:0] byte_q;
  logic [tcc_pkg::CELL_W-1:0] cell_q;
  logic [tcc_pkg::RROW_W-1:0] orow_q;
  logic [tcc_pkg::RCOL_W-1:0] ocol_q;
  logic                       last_q;

  logic                       col_last, row_last, sweep_last, read_ok, beat_last;
  logic [tcc_pkg::ROW_W-1:0]  bk_row;
  logic [tcc_pkg::COL_W-1:0]  bk_col;
  logic [tcc_pkg::ADDR_W-1:0] cur_addr, bk_addr, rd_addr, idx_next;
  logic [tcc_pkg::CELL_W-1:0] blank_cell;
  logic                       mem_we, mem_re;
  logic [tcc_pkg::ADDR_W-1:0] waddr, raddr;
  logic [tcc_pkg::CELL_W-1:0] wdata;
  logic                       e_sv;
  logic [tcc_pkg::CHAR_W-1:0] e_byte;
  logic [tcc_pkg::CELL_W-1:0] e_cell;

  // Cursor arithmetic and flags
  always_comb begin
    col_last   = (col_q == LastCol);
    row_last   = (row_q == LastRow);
    sweep_last = (idx_q == LastIdx);
    idx_next   = sweep_last ? '0 : idx_q + 1'b1;
    read_ok    = (int'(rrow_q) < tcc_pkg::ROWS) && (int'(rcol_q) < tcc_pkg::COLUMNS);
    beat_last  = (req_q != tcc_pkg::REQ_BACKSPACE) || (beat_q == LastBeat);
    // backspace target: step left, or to the end of the previous row
    bk_row = row_q;
    bk_col = col_q;
    if (col_q != '0) begin
      bk_col = col_q - 1'b1;
    end else if (row_q != '0) begin
      bk_row = row_q - 1'b1;
      bk_col = LastCol;
    end
    cur_addr = tcc_pkg::ADDR_W'(row_q) * ColsA + tcc_pkg::ADDR_W'(col_q);
    bk_addr  = tcc_pkg::ADDR_W'(bk_row) * ColsA + tcc_pkg::ADDR_W'(bk_col);
    rd_addr  = tcc_pkg::ADDR_W'(rrow_q) * ColsA + tcc_pkg::ADDR_W'(rcol_q);
    blank_cell = cmd_i.blank_rst ? {tcc_pkg::ATTR_RESET, tcc_pkg::CHAR_BLANK}
                                 : {attr_q, tcc_pkg::CHAR_BLANK};
  end

  // Memory port selection
  always_comb begin
    mem_we = 1'b0;
    waddr  = idx_q;
    wdata  = blank_cell;
    mem_re = 1'b0;
    raddr  = idx_q + ColsA;
    case (cmd_i.op)
      tcc_pkg::OP_PUT: begin
        mem_we = 1'b1;
        waddr  = cur_addr;
        wdata  = {attr_q, char_q};
      end
      tcc_pkg::OP_BKSP: begin
        mem_we = 1'b1;
        waddr  = bk_addr;
        wdata  = {attr_q, tcc_pkg::CHAR_BLANK};
      end
      tcc_pkg::OP_FILL: begin
        mem_we = 1'b1;
      end
      tcc_pkg::OP_COPY_WR: begin
        mem_we = 1'b1;
        wdata  = rdata_q;
      end
      tcc_pkg::OP_COPY_RD: begin
        mem_re = 1'b1;
      end
      tcc_pkg::OP_READ: begin
        mem_re = read_ok;
        raddr  = rd_addr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Next cursor, sweep and beat state
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    idx_d   = idx_q;
    beat_d  = beat_q;
    nl_d    = nl_q;
    rd_ok_d = rd_ok_q;
    case (cmd_i.op)
      tcc_pkg::OP_CAPTURE: begin
        beat_d  = '0;
        nl_d    = 1'b0;
        rd_ok_d = 1'b0;
      end
      tcc_pkg::OP_PUT: begin
        if (col_last) begin
          col_d = '0;
          if (!row_last) row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      tcc_pkg::OP_NEWLINE: begin
        col_d = '0;
        nl_d  = 1'b1;
        if (!row_last) row_d = row_q + 1'b1;
      end
      tcc_pkg::OP_BKSP: begin
        row_d = bk_row;
        col_d = bk_col;
      end
      tcc_pkg::OP_HOME: begin
        row_d = '0;
        col_d = '0;
      end
      tcc_pkg::OP_FILL,
      tcc_pkg::OP_COPY_WR: begin
        idx_d = idx_next;
      end
      tcc_pkg::OP_READ: begin
        rd_ok_d = read_ok;
      end
      tcc_pkg::OP_EMIT: begin
        beat_d = beat_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      idx_q   <= '0;
      beat_q  <= '0;
      nl_q    <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      idx_q   <= idx_d;
      beat_q  <= beat_d;
      nl_q    <= nl_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  // Text attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcc_pkg::ATTR_RESET;
    end else if (attr_we_i) begin
      attr_q <= attr_wdata_i;
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tcc_pkg::OP_CAPTURE) begin
      req_q  <= req_type_i;
      char_q <= char_code_i;
      rrow_q <= read_row_i;
      rcol_q <= read_col_i;
    end
  end

  // Echo and read-back fields of the current beat
  always_comb begin
    e_sv   = 1'b0;
    e_byte = tcc_pkg::CHAR_NONE;
    e_cell = '0;
    case (req_q)
      tcc_pkg::REQ_PUT: begin
        e_sv   = 1'b1;
        e_byte = char_q;
      end
      tcc_pkg::REQ_BACKSPACE: begin
        e_sv   = 1'b1;
        e_byte = (beat_q == tcc_pkg::BEAT_W'(1)) ? tcc_pkg::CHAR_BLANK
                                                  : tcc_pkg::CHAR_BACKSPACE;
      end
      tcc_pkg::REQ_NEWLINE_NZ: begin
        e_sv   = nl_q;
        e_byte = nl_q ? tcc_pkg::CHAR_NEWLINE : tcc_pkg::CHAR_NONE;
      end
      tcc_pkg::REQ_READ: begin
        e_cell = rd_ok_q ? rdata_q : '0;
      end
      default: begin
      end
    endcase
  end

  // Result register: holds a beat until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.op == tcc_pkg::OP_EMIT) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tcc_pkg::OP_EMIT) begin
      sv_q   <= e_sv;
      byte_q <= e_byte;
      cell_q <= e_cell;
      orow_q <= tcc_pkg::RROW_W'(row_q);
      ocol_q <= tcc_pkg::RCOL_W'(col_q);
      last_q <= beat_last;
    end
  end

  // Status to the controller
  always_comb begin
    stat_o.req        = req_q;
    stat_o.is_newline = (char_q == tcc_pkg::CHAR_NEWLINE);
    stat_o.col_zero   = (col_q == '0);
    stat_o.col_last   = col_last;
    stat_o.row_last   = row_last;
    stat_o.copy_phase = (idx_q < CopyEnd);
    stat_o.sweep_last = sweep_last;
    stat_o.beat_last  = beat_last;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign serial_valid_o = sv_q;
  assign serial_byte_o  = byte_q;
  assign cell_value_o   = cell_q;
  assign cursor_row_o   = orow_q;
  assign cursor_col_o   = ocol_q;
  assign last_o         = last_q;

endmodule

@@ rtl/core/tcc_ctrl.sv @@
// Controller state machine: sequences request handling, fills, scrolls and result beats.
// Depends on tcc_pkg; drives tcc_datapath through dp_cmd_t and reads dp_stat_t.
module tcc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcc_pkg::dp_stat_t   stat_i,
  output tcc_pkg::dp_cmd_t    cmd_o
);

  tcc_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcc_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath command
  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.op        = tcc_pkg::OP_NONE;
    cmd_o.blank_rst = 1'b0;
    case (state_q)
      // clearing pass after reset
      tcc_pkg::ST_INIT: begin
        cmd_o.op        = tcc_pkg::OP_FILL;
        cmd_o.blank_rst = 1'b1;
        if (stat_i.sweep_last) state_d = tcc_pkg::ST_IDLE;
      end
      tcc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = tcc_pkg::OP_CAPTURE;
          state_d  = tcc_pkg::ST_EXEC;
        end
      end
      tcc_pkg::ST_EXEC: begin
        state_d = tcc_pkg::ST_EMIT;
        case (stat_i.req)
          tcc_pkg::REQ_PUT: begin
            if (stat_i.is_newline) begin
              cmd_o.op = tcc_pkg::OP_NEWLINE;
              if (stat_i.row_last) state_d = tcc_pkg::ST_SCROLL_RD;
            end else begin
              cmd_o.op = tcc_pkg::OP_PUT;
              if (stat_i.col_last && stat_i.row_last) state_d = tcc_pkg::ST_SCROLL_RD;
            end
          end
          tcc_pkg::REQ_BACKSPACE: begin
            cmd_o.op = tcc_pkg::OP_BKSP;
          end
          tcc_pkg::REQ_CLEAR: begin
            cmd_o.op = tcc_pkg::OP_HOME;
            state_d  = tcc_pkg::ST_FILL;
          end
          tcc_pkg::REQ_NEWLINE_NZ: begin
            if (!stat_i.col_zero) begin
              cmd_o.op = tcc_pkg::OP_NEWLINE;
              if (stat_i.row_last) state_d = tcc_pkg::ST_SCROLL_RD;
            end
          end
          tcc_pkg::REQ_READ: begin
            cmd_o.op = tcc_pkg::OP_READ;
          end
          default: begin
          end
        endcase
      end
      tcc_pkg::ST_FILL: begin
        cmd_o.op = tcc_pkg::OP_FILL;
        if (stat_i.sweep_last) state_d = tcc_pkg::ST_EMIT;
      end
      // scroll: copy each cell up one row, then blank the bottom row
      tcc_pkg::ST_SCROLL_RD: begin
        if (stat_i.copy_phase) begin
          cmd_o.op = tcc_pkg::OP_COPY_RD;
          state_d  = tcc_pkg::ST_SCROLL_WR;
        end else begin
          cmd_o.op = tcc_pkg::OP_FILL;
          if (stat_i.sweep_last) state_d = tcc_pkg::ST_EMIT;
        end
      end
      tcc_pkg::ST_SCROLL_WR: begin
        cmd_o.op = tcc_pkg::OP_COPY_WR;
        state_d  = tcc_pkg::ST_SCROLL_RD;
      end
      tcc_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = tcc_pkg::OP_EMIT;
          if (stat_i.beat_last) state_d = tcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/text_console_cursor_engine_unit.sv @@
// Top level of the text console engine: joins the controller and the datapath.
// Depends on tcc_pkg, tcc_if, tcc_ctrl and tcc_datapath.
//
//  channel   direction  handshake      beat
//  req_i     in         valid/ready    req_type, char_code, read_row, read_col
//  rsp_o     out        valid/ready    serial_valid, serial_byte, cell_value,
//                                      cursor_row, cursor_col, last
//  attr cfg  in         we only        text_attribute_i
//
// Put, newline, read and unknown requests: the request is captured and executed, then its
// result beat is loaded; the next request is taken the cycle after that beat is loaded.
// Backspace: three beats, one per cycle while the sink keeps up.
// Clear: homes, then fills ROWS*COLUMNS cells (2000) through the single memory write port.
// Scroll: each copied cell is read, then written one row up; then the bottom row is blanked.
// After reset a clearing pass over ROWS*COLUMNS cells (2000) runs with req_i.ready low.
// The result register holds a beat while rsp_o stalls; the next beat waits behind it.
module text_console_cursor_engine_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       text_attribute_we_i,
  input  logic [tcc_pkg::ATTR_W-1:0] text_attribute_i,
  tcc_req_if.sink                    req_i,
  tcc_rsp_if.source                  rsp_o
);

  tcc_pkg::dp_cmd_t  cmd;
  tcc_pkg::dp_stat_t stat;
  logic              in_ready;

  tcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  assign req_i.ready = in_ready;

  tcc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .attr_we_i      (text_attribute_we_i),
    .attr_wdata_i   (text_attribute_i),
    .req_type_i     (req_i.req_type),
    .char_code_i    (req_i.char_code),
    .read_row_i     (req_i.read_row),
    .read_col_i     (req_i.read_col),
    .out_ready_i    (rsp_o.ready),
    .out_valid_o    (rsp_o.valid),
    .serial_valid_o (rsp_o.serial_valid),
    .serial_byte_o  (rsp_o.serial_byte),
    .cell_value_o   (rsp_o.cell_value),
    .cursor_row_o   (rsp_o.cursor_row),
    .cursor_col_o   (rsp_o.cursor_col),
    .last_o         (rsp_o.last)
  );

endmodule

@@ rtl/core/tcc_checker.sv @@
// Port-level checks on the text console engine, bound to the top level.
// Depends on tcc_pkg and text_console_cursor_engine_unit.
module tcc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic                        serial_valid_i,
  input logic [tcc_pkg::CHAR_W-1:0]  serial_byte_i,
  input logic [tcc_pkg::CELL_W-1:0]  cell_value_i,
  input logic [tcc_pkg::RROW_W-1:0]  cursor_row_i,
  input logic [tcc_pkg::RCOL_W-1:0]  cursor_col_i,
  input logic                        last_i
);

  // stalled beat holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(serial_byte_i)
      && $stable(cell_value_i) && $stable(last_i))
    else $error("response beat changed while stalled");

  // silent beats carry no byte
  a_silent_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !serial_valid_i |-> serial_byte_i == tcc_pkg::CHAR_NONE)
    else $error("byte present without serial_valid");

  // echo beats never carry a read-back cell
  a_echo_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && serial_valid_i |-> cell_value_i == '0)
    else $error("cell value on an echo beat");

  // cursor stays on screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (int'(cursor_row_i) < tcc_pkg::ROWS)
      && (int'(cursor_col_i) < tcc_pkg::COLUMNS))
    else $error("cursor outside the screen");

endmodule

bind text_console_cursor_engine_unit tcc_checker u_tcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .serial_valid_i (rsp_o.serial_valid),
  .serial_byte_i  (rsp_o.serial_byte),
  .cell_value_i   (rsp_o.cell_value),
  .cursor_row_i   (rsp_o.cursor_row),
  .cursor_col_i   (rsp_o.cursor_col),
  .last_i         (rsp_o.last)
);
